### src/pls_pkg.sv
// positional list store: shared types and codes
// item structs, operation and status codes, cell control word
// no dependencies
`timescale 1ns / 1ps

package pls_pkg;

    // operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // cell modes
    localparam logic [2:0] CM_HOLD   = 3'd0;
    localparam logic [2:0] CM_INSERT = 3'd1;
    localparam logic [2:0] CM_REMOVE = 3'd2;
    localparam logic [2:0] CM_WRITE  = 3'd3;
    localparam logic [2:0] CM_LOAD   = 3'd4;
    localparam logic [2:0] CM_SHIFT  = 3'd5;

    // input item
    typedef struct packed {
        logic [2:0]  func;
        logic [6:0]  position;
        logic [63:0] value_in;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [63:0] value_out;
        logic [1:0]  status;
        logic [6:0]  count;
        logic        is_empty;
    } t_result;

    // control broadcast to every cell
    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] pos;
    } t_cell_ctrl;

endpackage

### src/positional_list_store_core.sv
// positional list store: top level with command decode and cell chain
// sequencing: a get loads the read lane, then holds busy while the lane moves one cell toward
// cell 0 per cycle, and strobes after the addressed word has reached cell 0; all other items,
// and a get at a bad position, strobe the next cycle, and one may be accepted every cycle while not busy
// reset: count cleared, no strobe; stored words are undefined until written
// depends on pls_pkg and pls_cell
`timescale 1ns / 1ps

module positional_list_store_core #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pls_pkg::t_cmd     i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output pls_pkg::t_result  o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = ((CW > 7) ? CW : 7) + 1;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_busy;
    logic                n_busy;
    logic [6:0]          r_shift_cnt;
    logic [6:0]          n_shift_cnt;
    logic                r_strobe;
    logic                n_strobe;
    logic [63:0]         r_value;
    logic [63:0]         n_value;
    logic [1:0]          r_status;
    logic [1:0]          n_status;

    logic                accept;
    logic [W-1:0]        pos_w;
    logic [W-1:0]        cnt_w;
    logic [W-1:0]        cap_w;
    logic [CW+6:0]       cnt_pad;
    pls_pkg::t_cell_ctrl ctrl;

    logic [63:0]         word [CAPACITY];
    logic [63:0]         lane [CAPACITY];

    assign accept = start && !r_busy;
    assign pos_w  = W'(i_cmd.position);
    assign cnt_w  = W'(r_count);
    assign cap_w  = W'(CAPACITY);

    // command decode and read lane sequencing
    always_comb begin
        n_count     = r_count;
        n_busy      = r_busy;
        n_shift_cnt = r_shift_cnt;
        n_strobe    = 1'b0;
        n_value     = r_value;
        n_status    = r_status;
        ctrl.mode   = pls_pkg::CM_HOLD;
        ctrl.pos    = i_cmd.position;
        if (accept) begin
            n_strobe = 1'b1;
            n_value  = '0;
            n_status = pls_pkg::ST_DONE;
            unique case (i_cmd.func)
                pls_pkg::OP_INSERT: begin
                    if (pos_w > cnt_w) begin
                        n_status = pls_pkg::ST_BADPOS;
                    end else if (cnt_w >= cap_w) begin
                        n_status = pls_pkg::ST_FULL;
                    end else begin
                        ctrl.mode = pls_pkg::CM_INSERT;
                        n_count   = r_count + CW'(1);
                    end
                end
                pls_pkg::OP_REMOVE: begin
                    if (pos_w >= cnt_w) begin
                        n_status = pls_pkg::ST_BADPOS;
                    end else begin
                        ctrl.mode = pls_pkg::CM_REMOVE;
                        n_count   = r_count - CW'(1);
                    end
                end
                pls_pkg::OP_GET: begin
                    if (pos_w >= cnt_w) begin
                        n_status = pls_pkg::ST_BADPOS;
                    end else begin
                        ctrl.mode   = pls_pkg::CM_LOAD;
                        n_strobe    = 1'b0;
                        n_busy      = 1'b1;
                        n_shift_cnt = i_cmd.position;
                    end
                end
                pls_pkg::OP_SET: begin
                    if (pos_w >= cnt_w) begin
                        n_status = pls_pkg::ST_BADPOS;
                    end else begin
                        ctrl.mode = pls_pkg::CM_WRITE;
                    end
                end
                pls_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_status = pls_pkg::ST_DONE;
                end
            endcase
        end else if (r_busy) begin
            // walk the read lane down until the addressed word reaches cell 0
            if (r_shift_cnt == 7'd0) begin
                n_busy   = 1'b0;
                n_strobe = 1'b1;
                n_value  = lane[0];
                n_status = pls_pkg::ST_DONE;
            end else begin
                ctrl.mode   = pls_pkg::CM_SHIFT;
                n_shift_cnt = r_shift_cnt - 7'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_shift_cnt <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_shift_cnt <= n_shift_cnt;
            r_strobe    <= n_strobe;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
    end

    // chain of cells
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [63:0] lower_word;
            logic [63:0] upper_word;
            logic [63:0] upper_lane;

            if (g == 0) begin : g_first
                assign lower_word = '0;
            end else begin : g_mid_lo
                assign lower_word = word[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign upper_word = '0;
                assign upper_lane = '0;
            end else begin : g_mid_hi
                assign upper_word = word[g+1];
                assign upper_lane = lane[g+1];
            end

            pls_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_value      (i_cmd.value_in),
                .i_lower_word (lower_word),
                .i_upper_word (upper_word),
                .i_upper_lane (upper_lane),
                .o_word       (word[g]),
                .o_lane       (lane[g])
            );
        end
    endgenerate

    // outputs; count is read after the update of the item being reported
    assign cnt_pad            = {7'd0, r_count};
    assign busy               = r_busy;
    assign o_strobe           = r_strobe;
    assign o_result.value_out = r_value;
    assign o_result.status    = r_status;
    assign o_result.count     = cnt_pad[6:0];
    assign o_result.is_empty  = (r_count == '0);

endmodule

### src/pls_cell.sv
// positional list store: one storage cell of the chain
// holds one word and one read lane stage, trades with both neighbours
// depends on pls_pkg
`timescale 1ns / 1ps

module pls_cell #(
    parameter int CAPACITY = 64,
    parameter int IDX      = 0
) (
    input  logic                  i_clk,
    input  pls_pkg::t_cell_ctrl   i_ctrl,
    input  logic [63:0]           i_value,
    input  logic [63:0]           i_lower_word,
    input  logic [63:0]           i_upper_word,
    input  logic [63:0]           i_upper_lane,
    output logic [63:0]           o_word,
    output logic [63:0]           o_lane
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (IW > 7) ? IW : 7;

    logic [63:0]   r_word;
    logic [63:0]   n_word;
    logic [63:0]   r_lane;
    logic [63:0]   n_lane;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] idx_ext;
    logic          above;
    logic          here;

    // where this cell sits against the addressed position
    assign pos_ext = PW'(i_ctrl.pos);
    assign idx_ext = PW'(IDX);
    assign above   = idx_ext > pos_ext;
    assign here    = idx_ext == pos_ext;

    // next word and read lane
    always_comb begin
        n_word = r_word;
        n_lane = r_lane;
        unique case (i_ctrl.mode)
            pls_pkg::CM_INSERT: begin
                if (above) begin
                    n_word = i_lower_word;
                end else if (here) begin
                    n_word = i_value;
                end
            end
            pls_pkg::CM_REMOVE: begin
                if (above || here) begin
                    n_word = i_upper_word;
                end
            end
            pls_pkg::CM_WRITE: begin
                if (here) begin
                    n_word = i_value;
                end
            end
            pls_pkg::CM_LOAD: begin
                n_lane = r_word;
            end
            pls_pkg::CM_SHIFT: begin
                n_lane = i_upper_lane;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // storage
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_lane <= n_lane;
    end

    assign o_word = r_word;
    assign o_lane = r_lane;

endmodule
